@@ hdl/isc_pkg.sv @@
`default_nettype none

package isc_pkg;

    // Counts are kept modulo this value; every stored sum stays below it.
    localparam int unsigned MODULUS   = 5000000;
    localparam int          COUNT_W   = 23;
    localparam int          VALUE_W   = 10;
    localparam int          LENGTH_W  = 6;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(2);

    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_UPDATE,
        ST_DONE
    } tree_state_t;

    // Sum of two residues, folded back below the modulus.
    function automatic count_t add_mod(input count_t a, input count_t b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (COUNT_W+1)'(MODULUS))
        begin
            s = s - (COUNT_W+1)'(MODULUS);
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/increasing_subsequence_counter.sv @@
// Each item runs an update walk on every level and, before each level above the first, a query
//   walk over the level below; one tree step per cycle, set by the single read port of the tree
//   memory. One item at a time.
// The next item is taken while a result waits in the output register.
// Reset: asynchronous, active low. Afterwards the tree memory is swept to zero, one entry a cycle;
//   no item is taken until it ends.
`default_nettype none

module increasing_subsequence_counter
    import isc_pkg::*;
#(
    parameter int VALUES     = 1024,
    parameter int MAX_LEVELS = 50
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // configuration: subsequence length
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [LENGTH_W-1:0] cfg_data,

    // input items
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic                last,

    // results
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [COUNT_W-1:0]       count,
    output logic                     final_res
);

    // Tree geometry. Entry {level, pos-1} holds Fenwick node pos of that level.
    localparam int POS_W     = $clog2(VALUES);
    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int ADDR_W    = LVL_W + POS_W;
    localparam int MEM_DEPTH = MAX_LEVELS * (2 ** POS_W);
    // Walking index: holds 1..VALUES plus one lowbit step past the end.
    localparam int IDX_W     = POS_W + 2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LVL_W-1:0]  lvl_t;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    tree_state_t         st_reg, st_next;
    addr_t               clr_addr_reg, clr_addr_next;
    lvl_t                lvl_reg, lvl_next;         // level being worked on
    lvl_t                top_reg, top_next;         // highest level for this item
    idx_t                pos_reg, pos_next;         // value + 1
    idx_t                idx_reg, idx_next;         // Fenwick walk pointer
    logic                pend_reg, pend_next;       // a tree read is in flight
    addr_t               pend_addr_reg, pend_addr_next;
    count_t              acc_reg, acc_next;         // query accumulator
    count_t              ways_reg, ways_next;       // amount added at this level
    count_t              run_reg, run_next;         // running count
    logic                last_reg, last_next;
    logic [LENGTH_W-1:0] length_reg;
    logic                out_valid_reg, out_valid_next;
    count_t              out_count_reg, out_count_next;
    logic                out_final_reg, out_final_next;

    // ---------------------------------------------------------------
    // Tree memory: one read and one write port, registered read data.
    // The update walk visits strictly increasing nodes and a query only
    // nodes below pos, so a write never meets a read of the same entry
    // in the same cycle.
    // ---------------------------------------------------------------
    count_t              tree_mem [MEM_DEPTH];
    logic                rd_en;
    addr_t               rd_addr;
    count_t              rd_data_reg;
    logic                wr_en;
    addr_t               wr_addr;
    count_t              wr_data;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= tree_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tree_mem[wr_addr] <= wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Walk control
    // ---------------------------------------------------------------
    logic  q_issue, q_done;
    logic  u_issue, u_done;
    logic  clr_done;
    logic  slot_free;
    logic  in_xfer;
    idx_t  lowbit;

    assign q_issue   = (idx_reg != '0);
    assign q_done    = !q_issue && !pend_reg;
    assign u_issue   = (idx_reg <= IDX_W'(VALUES));
    assign u_done    = !u_issue && !pend_reg;
    assign clr_done  = (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1));
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_xfer   = in_valid && !in_stall;
    assign lowbit    = idx_reg & (~idx_reg + IDX_W'(1));

    // Clamped input value and level count for an arriving item.
    logic [31:0] v_wide;
    logic [31:0] v_clamp;
    logic [6:0]  len_clamp;

    always_comb
    begin
        v_wide  = {{(32-VALUE_W){1'b0}}, value};
        v_clamp = (v_wide >= 32'(VALUES)) ? 32'(VALUES - 1) : v_wide;
        if (length_reg == '0)
        begin
            len_clamp = 7'd1;
        end
        else if ({1'b0, length_reg} > 7'(MAX_LEVELS))
        begin
            len_clamp = 7'(MAX_LEVELS);
        end
        else
        begin
            len_clamp = {1'b0, length_reg};
        end
    end

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = ST_UPDATE;
                end
            end
            ST_QUERY:
            begin
                if (q_done)
                begin
                    st_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (u_done)
                begin
                    st_next = (lvl_reg == top_reg) ? ST_DONE : ST_QUERY;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        lvl_next       = lvl_reg;
        top_next       = top_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        acc_next       = acc_reg;
        ways_next      = ways_reg;
        run_next       = run_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_count_next = out_count_reg;
        out_final_next = out_final_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        case (st_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // level 1 adds one way at pos
                    pos_next  = IDX_W'(v_clamp + 32'd1);
                    idx_next  = IDX_W'(v_clamp + 32'd1);
                    lvl_next  = '0;
                    top_next  = LVL_W'(len_clamp - 7'd1);
                    ways_next = COUNT_W'(1);
                    last_next = last;
                end
            end
            ST_QUERY:
            begin
                // prefix sum of the level below over nodes 1..pos-1
                if (q_issue)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = {lvl_reg - LVL_W'(1), POS_W'(idx_reg - IDX_W'(1))};
                    idx_next  = idx_reg & (idx_reg - IDX_W'(1));
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    acc_next = add_mod(acc_reg, rd_data_reg);
                end
                if (q_done)
                begin
                    ways_next = acc_reg;
                    idx_next  = pos_reg;
                end
            end
            ST_UPDATE:
            begin
                // read-modify-write up the tree, one node per cycle
                if (u_issue)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = {lvl_reg, POS_W'(idx_reg - IDX_W'(1))};
                    pend_addr_next = {lvl_reg, POS_W'(idx_reg - IDX_W'(1))};
                    idx_next       = idx_reg + lowbit;
                    pend_next      = 1'b1;
                end
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg;
                    wr_data = add_mod(rd_data_reg, ways_reg);
                end
                if (u_done)
                begin
                    if (lvl_reg == top_reg)
                    begin
                        run_next = add_mod(run_reg, ways_reg);
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LVL_W'(1);
                        idx_next = pos_reg - IDX_W'(1);
                        acc_next = '0;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = run_reg;
                    out_final_next = last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            run_reg       <= '0;
            length_reg    <= LENGTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_addr_reg  <= clr_addr_next;
            pend_reg      <= pend_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                length_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        lvl_reg       <= lvl_next;
        top_reg       <= top_next;
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        acc_reg       <= acc_next;
        ways_reg      <= ways_next;
        last_reg      <= last_next;
        out_count_reg <= out_count_next;
        out_final_reg <= out_final_next;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign in_stall  = (st_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign count     = out_count_reg;
    assign final_res = out_final_reg;

endmodule

`default_nettype wire

@@ sim/increasing_subsequence_counter_tb.sv @@
module increasing_subsequence_counter_tb;
    import isc_pkg::*;

    localparam int          DOMAIN           = 1024;
    localparam int          LEVEL_CAP        = 50;
    localparam int unsigned COUNT_MOD        = 5000000;
    localparam int          LENGTH_AT_RESET  = 2;
    localparam int          CYCLE_LIMIT      = 2000000;
    localparam int          SHOWN_MISMATCHES = 10;
    // One full item at the deepest length, to catch stray transfers at the end.
    localparam int          DRAIN_CYCLES     = 1300;

    typedef struct packed {
        count_t count;
        logic   final_res;
    } tally_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LENGTH_W-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [VALUE_W-1:0]  value     = '0;
    logic                last      = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    count_t              count;
    logic                final_res;

    increasing_subsequence_counter #(
        .VALUES     (DOMAIN),
        .MAX_LEVELS (LEVEL_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .count     (count),
        .final_res (final_res)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: one Fenwick tree per level over positions 1..DOMAIN,
    // slot 0 unused. State only clears at reset, never between phases.
    // ------------------------------------------------------------------
    count_t              level_sums [LEVEL_CAP][DOMAIN+1];
    count_t              running_total;
    logic [LENGTH_W-1:0] length_now;
    tally_t              expected_tallies [$];

    int mismatches  = 0;
    int cycles_run  = 0;
    int burst_left  = 0;
    int walk_pos    = 0;

    function automatic count_t mod_add(input count_t a, input count_t b);
        int unsigned s;
        s = a + b;
        if (s >= COUNT_MOD)
        begin
            s = s - COUNT_MOD;
        end
        return count_t'(s);
    endfunction

    // Sum of one level over positions 1..pos.
    function automatic count_t sum_through(input int lvl, input int pos);
        count_t acc;
        int     p;
        acc = '0;
        p   = pos;
        while (p != 0)
        begin
            acc = mod_add(acc, level_sums[lvl][p]);
            p   = p & (p - 1);
        end
        return acc;
    endfunction

    function automatic void tree_add(input int lvl, input int pos, input count_t amount);
        int p;
        p = pos;
        while (p != 0 && p <= DOMAIN)
        begin
            level_sums[lvl][p] = mod_add(level_sums[lvl][p], amount);
            p = p + (p & -p);
        end
    endfunction

    // Ways to end an increasing run of each length at v; top level feeds the total.
    function automatic tally_t predict_tally(input logic [VALUE_W-1:0] v, input logic fin);
        int     levels;
        int     pos;
        count_t ways;
        tally_t t;
        levels = int'(length_now);
        if (levels == 0)
        begin
            levels = 1;
        end
        if (levels > LEVEL_CAP)
        begin
            levels = LEVEL_CAP;
        end
        pos = int'(v) + 1;
        if (pos > DOMAIN)
        begin
            pos = DOMAIN;
        end
        for (int lvl = 0; lvl < levels; lvl++)
        begin
            ways = (lvl == 0) ? count_t'(1) : sum_through(lvl - 1, pos - 1);
            tree_add(lvl, pos, ways);
            if (lvl == levels - 1)
            begin
                running_total = mod_add(running_total, ways);
            end
        end
        t.count     = running_total;
        t.final_res = fin;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random walk over the value domain. Mostly climbing so that long
    // increasing subsequences exist; the rest jumps, jitters in place
    // (repeats test strictness) or falls back.
    function automatic logic [VALUE_W-1:0] next_value(input int up_weight);
        int roll;
        int rest;
        roll = $urandom_range(0, 99);
        rest = (100 - up_weight) / 3;
        if (roll < up_weight)
        begin
            walk_pos = walk_pos + int'($urandom_range(1, 8));
        end
        else if (roll < up_weight + rest)
        begin
            walk_pos = int'($urandom_range(0, DOMAIN - 1));
        end
        else if (roll < up_weight + 2 * rest)
        begin
            walk_pos = walk_pos + int'($urandom_range(0, 4)) - 2;
        end
        else
        begin
            walk_pos = walk_pos - int'($urandom_range(1, 64));
        end
        if (walk_pos > DOMAIN - 1)
        begin
            walk_pos = int'($urandom_range(0, 31));
        end
        if (walk_pos < 0)
        begin
            walk_pos = int'($urandom_range(0, 15));
        end
        return walk_pos[VALUE_W-1:0];
    endfunction

    // One input transfer. Valid stays high across a burst; between bursts
    // the sender drops valid for a short random pause. Long bursts give stretches
    // with no sender idling at all.
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic fin);
        in_valid <= 1'b1;
        value    <= v;
        last     <= fin;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        expected_tallies.push_back(predict_tally(v, fin));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : int'($urandom_range(0, 10));
        end
    endtask

    // Every item yields a result, so an empty queue means the block is idle.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_tallies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_length(input logic [LENGTH_W-1:0] len);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        length_now = len;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [LENGTH_W-1:0] len, input int items,
                             input int up_weight);
        write_length(len);
        repeat (items)
        begin
            send_item(next_value(up_weight), $urandom_range(0, 15) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset length applies with no write; items after last keep extending.
    task automatic test_reset_length();
        send_item(10'd5,    1'b0);
        send_item(10'd3,    1'b0);
        send_item(10'd1023, 1'b1);
        send_item(10'd7,    1'b0);
        send_item(10'd0,    1'b0);
    endtask

    // Zero length acts as one, 63 saturates to the level cap, and the
    // levels keep what earlier settings wrote into them.
    task automatic test_length_extremes();
        write_length(6'd0);
        send_item(10'd4, 1'b0);
        send_item(10'd2, 1'b0);
        send_item(10'd9, 1'b1);
        write_length(6'd1);
        send_item(10'd1023, 1'b0);
        send_item(10'd0,    1'b0);
        write_length(6'd63);
        send_item(10'd1, 1'b0);
        send_item(10'd2, 1'b0);
        send_item(10'd3, 1'b0);
        send_item(10'd4, 1'b1);
        write_length(6'd50);
        send_item(10'd600,  1'b0);
        send_item(10'd700,  1'b0);
        send_item(10'd1023, 1'b1);
        send_item(10'd800,  1'b0);
    endtask

    // Short lengths are cheap per item, so most random traffic lives here;
    // counts grow past the modulus once length reaches about five.
    task automatic test_random_short();
        for (int ph = 0; ph < 6; ph++)
        begin
            run_phase(6'($urandom_range(1, 8)), 55, 60);
        end
    endtask

    task automatic test_random_mid();
        run_phase(6'($urandom_range(9, 30)), 40, 70);
    endtask

    // Full depth: a mostly climbing walk so the top level actually fills.
    task automatic test_random_deep();
        run_phase(6'd50, 60, 90);
    endtask

    // ------------------------------------------------------------------
    // Result side: checks each transfer, and stalls on a rotating bit
    // pattern that is redrawn now and then (sometimes all zero).
    // ------------------------------------------------------------------
    logic [15:0] stall_bits = '0;
    int          stall_age  = 0;

    always @(posedge clk)
    begin : result_monitor
        tally_t want;
        if (out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_tallies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                begin
                    $display("unexpected transfer: count %0d final_res %b", count, final_res);
                end
            end
            else
            begin
                want = expected_tallies.pop_front();
                if (count !== want.count || final_res !== want.final_res)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                    begin
                        $display("mismatch: count exp %0d got %0d, final_res exp %b got %b",
                                 want.count, count, want.final_res, final_res);
                    end
                end
            end
        end
        if (stall_age == 0)
        begin
            stall_bits <= ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
            stall_age  <= $urandom_range(64, 512);
        end
        else
        begin
            stall_bits <= {stall_bits[0], stall_bits[15:1]};
            stall_age  <= stall_age - 1;
        end
        out_stall <= stall_bits[0];
    end

    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        for (int l = 0; l < LEVEL_CAP; l++)
        begin
            for (int p = 0; p <= DOMAIN; p++)
            begin
                level_sums[l][p] = '0;
            end
        end
        running_total = '0;
        length_now    = LENGTH_W'(LENGTH_AT_RESET);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the block sweeps its tree store after reset; the first transfer waits it out
        test_reset_length();
        test_length_extremes();
        test_random_short();
        test_random_mid();
        test_random_deep();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/isc_pkg.sv
hdl/increasing_subsequence_counter.sv
sim/increasing_subsequence_counter_tb.sv
